/* hdl/trn_pkg.sv */
package trn_pkg;

  localparam logic [7:0] B_SE   = 8'd240;
  localparam logic [7:0] B_SB   = 8'd250;
  localparam logic [7:0] B_WILL = 8'd251;
  localparam logic [7:0] B_WONT = 8'd252;
  localparam logic [7:0] B_DO   = 8'd253;
  localparam logic [7:0] B_DONT = 8'd254;
  localparam logic [7:0] B_IAC  = 8'd255;
  localparam logic [7:0] B_CR   = 8'd13;
  localparam logic [7:0] B_LF   = 8'd10;
  localparam logic [7:0] OPT_BIN   = 8'd0;
  localparam logic [7:0] OPT_ECHO  = 8'd1;
  localparam logic [7:0] OPT_SGA   = 8'd3;
  localparam logic [7:0] OPT_TTYPE = 8'd24;
  localparam logic [7:0] OPT_NAWS  = 8'd31;

  // register indexes
  localparam logic [1:0] REG_COLS  = 2'd0;
  localparam logic [1:0] REG_ROWS  = 2'd1;
  localparam logic [1:0] REG_TTEXT = 2'd2;
  localparam logic [1:0] REG_TLEN  = 2'd3;

  // longest burst of results from one word
  localparam int unsigned MAX_RES = 22;
  localparam int unsigned RES_W   = 5;

  // parse phases, one-hot
  typedef enum logic [5:0] {
    PH_DATA   = 6'b000001,
    PH_DCR    = 6'b000010,
    PH_CMD    = 6'b000100,
    PH_NEG    = 6'b001000,
    PH_SUB    = 6'b010000,
    PH_SUBCMD = 6'b100000
  } phase_e;

  // message kinds queued for the output sequencer
  typedef enum logic [3:0] {
    MSG_NONE   = 4'd0,
    MSG_DATA1  = 4'd1,
    MSG_DATA2  = 4'd2,
    MSG_R3     = 4'd3,
    MSG_R3X2   = 4'd4,
    MSG_R3NAWS = 4'd5,
    MSG_NAWS   = 4'd6,
    MSG_TTYPE  = 4'd7
  } msg_e;

  typedef struct packed {
    logic       mode;
    logic [7:0] rx_byte;
  } in_word_t;

  typedef struct packed {
    logic       channel;
    logic [7:0] out_byte;
    logic       message_end;
    logic       run_last;
    logic       naws_on;
    logic       binary_on;
    logic       binary_refused;
  } out_word_t;

  // job handed from the parser to the emitter
  typedef struct packed {
    msg_e       kind;
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] v0;
    logic [7:0] o0;
    logic [7:0] v1;
    logic [7:0] o1;
    logic       naws_on;
    logic       binary_on;
    logic       binary_refused;
  } job_t;

endpackage

/* hdl/telnet_receive_negotiator.sv */
// Telnet receive negotiator. One input word per cycle is parsed and its job
// registered; the job is then played out one result word per cycle while
// out_stall_i is low, from a small ROM-like sequencer, so a word that causes n
// results (1 to 22) holds the output until its last result is taken. The next
// input word is taken as the last result of the current burst is accepted, or at
// once when the job register is empty or yields nothing. Configuration must be
// written through the plain write port while idle; this is not enforced.
module telnet_receive_negotiator #(
  parameter int unsigned TERM_TYPE_MAX = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_index_i,
  input  logic [63:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  trn_pkg::in_word_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output trn_pkg::out_word_t out_data_o
);

  logic [15:0] cols_q, rows_q;
  logic [63:0] text_q;
  logic [3:0]  tlen_q;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cols_q <= '0; rows_q <= '0; text_q <= '0; tlen_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        trn_pkg::REG_COLS:  cols_q <= cfg_data_i[15:0];
        trn_pkg::REG_ROWS:  rows_q <= cfg_data_i[15:0];
        trn_pkg::REG_TTEXT: text_q <= cfg_data_i;
        default:            tlen_q <= cfg_data_i[3:0];
      endcase
    end
  end

  trn_pkg::job_t job_d, job_q;
  logic [4:0] idx_q;
  logic take, busy, last, adv;
  trn_pkg::out_word_t ow;
  logic [3:0] tl;

  trn_parser u_parser (
    .clk_i, .rst_ni, .take_i(take), .word_i(in_data_i), .job_o(job_d)
  );

  assign busy = (job_q.kind != trn_pkg::MSG_NONE);
  assign adv  = busy && !out_stall_i;
  assign in_stall_o = busy && !(adv && last);
  assign take = in_valid_i && !in_stall_o;
  assign out_valid_o = busy;
  assign out_data_o = ow;
  assign tl = (tlen_q > 4'(TERM_TYPE_MAX)) ? 4'(TERM_TYPE_MAX) : tlen_q;

  // escaped-byte stream helpers: position of escape list
  logic [7:0] eb [8];
  logic [7:0] nb [8];
  logic [7:0] tb [8];
  logic [4:0] epos [9];
  logic [4:0] tpos [9];
  logic [7:0] sel;
  logic       hit;
  always_comb begin
    for (int i = 0; i < 8; i++) tb[i] = text_q[8*i +: 8];
    nb[0] = cols_q[15:8]; nb[1] = cols_q[7:0]; nb[2] = rows_q[15:8]; nb[3] = rows_q[7:0];
    for (int i = 4; i < 8; i++) nb[i] = 8'd0;
    for (int i = 0; i < 8; i++)
      eb[i] = (job_q.kind == trn_pkg::MSG_TTYPE) ? tb[i] : nb[i];
    // start index of each escaped byte
    epos[0] = (job_q.kind == trn_pkg::MSG_TTYPE) ? 5'd4 :
              (job_q.kind == trn_pkg::MSG_R3NAWS) ? 5'd6 : 5'd3;
    for (int i = 0; i < 8; i++)
      epos[i+1] = epos[i] + ((eb[i] == trn_pkg::B_IAC) ? 5'd2 : 5'd1);
    for (int i = 0; i < 9; i++) tpos[i] = epos[i];
  end

  // result word for the current index
  always_comb begin
    logic [4:0] nbytes, endp;
    ow = '0;
    nbytes = (job_q.kind == trn_pkg::MSG_TTYPE) ? 5'(tl) : 5'd4;
    endp = tpos[0];
    sel = 8'd0; hit = 1'b0;
    for (int i = 0; i < 8; i++) begin
      if (5'(i) < nbytes) begin
        if (idx_q == tpos[i]) begin sel = eb[i]; hit = 1'b1; end
        if (eb[i] == trn_pkg::B_IAC && idx_q == tpos[i] + 5'd1) begin
          sel = trn_pkg::B_IAC; hit = 1'b1;
        end
        endp = tpos[i+1];
      end
    end
    ow.channel = 1'b1;
    last = 1'b0;
    unique case (job_q.kind)
      trn_pkg::MSG_DATA1: begin
        ow.channel = 1'b0; ow.out_byte = job_q.b0; last = 1'b1;
      end
      trn_pkg::MSG_DATA2: begin
        ow.channel = 1'b0; ow.out_byte = (idx_q == 5'd0) ? job_q.b0 : job_q.b1;
        last = (idx_q == 5'd1);
      end
      trn_pkg::MSG_R3, trn_pkg::MSG_R3X2: begin
        unique case (idx_q)
          5'd0, 5'd3: ow.out_byte = trn_pkg::B_IAC;
          5'd1: ow.out_byte = job_q.v0;
          5'd2: ow.out_byte = job_q.o0;
          5'd4: ow.out_byte = job_q.v1;
          default: ow.out_byte = job_q.o1;
        endcase
        ow.message_end = (idx_q == 5'd2) || (idx_q == 5'd5);
        last = (job_q.kind == trn_pkg::MSG_R3) ? (idx_q == 5'd2) : (idx_q == 5'd5);
      end
      trn_pkg::MSG_NONE: begin
        ow.out_byte = 8'd0;
      end
      default: begin
        // R3NAWS prefix, then NAWS or TTYPE report
        logic [4:0] k;
        k = (job_q.kind == trn_pkg::MSG_R3NAWS) ? 5'd3 : 5'd0;
        if (job_q.kind == trn_pkg::MSG_R3NAWS && idx_q < 5'd3) begin
          unique case (idx_q)
            5'd0: ow.out_byte = trn_pkg::B_IAC;
            5'd1: ow.out_byte = trn_pkg::B_WILL;
            default: ow.out_byte = trn_pkg::OPT_NAWS;
          endcase
          ow.message_end = (idx_q == 5'd2);
        end else if (idx_q == k) ow.out_byte = trn_pkg::B_IAC;
        else if (idx_q == k + 5'd1) ow.out_byte = trn_pkg::B_SB;
        else if (idx_q == k + 5'd2)
          ow.out_byte = (job_q.kind == trn_pkg::MSG_TTYPE) ? trn_pkg::OPT_TTYPE
                                                          : trn_pkg::OPT_NAWS;
        else if (job_q.kind == trn_pkg::MSG_TTYPE && idx_q == 5'd3) ow.out_byte = 8'd0;
        else if (hit) ow.out_byte = sel;
        else if (idx_q == endp) ow.out_byte = trn_pkg::B_IAC;
        else begin
          ow.out_byte = trn_pkg::B_SE; ow.message_end = 1'b1; last = 1'b1;
        end
      end
    endcase
    ow.run_last = last;
    ow.naws_on = job_q.naws_on;
    ow.binary_on = job_q.binary_on;
    ow.binary_refused = job_q.binary_refused;
  end

  // job register and burst index
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      job_q <= '0;
      idx_q <= '0;
    end else if (take) begin
      job_q <= job_d;
      idx_q <= '0;
    end else if (adv) begin
      if (last) job_q.kind <= trn_pkg::MSG_NONE;
      idx_q <= idx_q + 5'd1;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) busy |-> out_valid_o)
    else $error("job without valid");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (out_valid_o && !out_stall_i && !last) |=> (idx_q == $past(idx_q) + 5'd1))
    else $error("index did not step");
  assert property (@(posedge clk_i) disable iff (!rst_ni) busy |-> (idx_q < 5'(trn_pkg::MAX_RES)))
    else $error("burst overran");

endmodule

/* hdl/trn_parser.sv */
module trn_parser (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            take_i,
  input  trn_pkg::in_word_t word_i,
  output trn_pkg::job_t   job_o
);

  trn_pkg::phase_e phase_q, phase_d;
  logic [1:0] verb_q, verb_d;
  logic lbon_q, lbon_d, lbask_q, lbask_d, rbon_q, rbon_d, rbask_q, rbask_d;
  logic tt_q, tt_d, ws_q, ws_d, ref_q, ref_d;
  logic [1:0] cnt_q, cnt_d;
  logic [7:0] h0_q, h0_d, h1_q, h1_d;
  trn_pkg::job_t j;
  logic [7:0] b;

  always_comb begin
    phase_d = phase_q; verb_d = verb_q;
    lbon_d = lbon_q; lbask_d = lbask_q; rbon_d = rbon_q; rbask_d = rbask_q;
    tt_d = tt_q; ws_d = ws_q; ref_d = ref_q;
    cnt_d = cnt_q; h0_d = h0_q; h1_d = h1_q;
    j = '0;
    j.kind = trn_pkg::MSG_NONE;
    b = word_i.rx_byte;
    if (word_i.mode) begin
      // binary request
      ref_d = 1'b0;
      if (!lbon_q) lbask_d = 1'b1;
      if (!rbon_q) rbask_d = 1'b1;
      j.v0 = trn_pkg::B_WILL; j.o0 = trn_pkg::OPT_BIN;
      j.v1 = trn_pkg::B_DO;   j.o1 = trn_pkg::OPT_BIN;
      if (!lbon_q && !rbon_q) j.kind = trn_pkg::MSG_R3X2;
      else if (!lbon_q) j.kind = trn_pkg::MSG_R3;
      else if (!rbon_q) begin
        j.kind = trn_pkg::MSG_R3; j.v0 = trn_pkg::B_DO;
      end
    end else begin
      unique case (phase_q)
        trn_pkg::PH_DCR: begin
          phase_d = trn_pkg::PH_DATA;
          j.b0 = trn_pkg::B_CR; j.b1 = b;
          if (b == trn_pkg::B_LF) j.kind = trn_pkg::MSG_DATA2;
          else if (b == 8'd0) j.kind = trn_pkg::MSG_DATA1;
          else if (b == trn_pkg::B_IAC) begin
            j.kind = trn_pkg::MSG_DATA1; phase_d = trn_pkg::PH_CMD;
          end else if (rbon_q) j.kind = trn_pkg::MSG_DATA2;
          else if (b == trn_pkg::B_CR) begin
            j.kind = trn_pkg::MSG_DATA1; phase_d = trn_pkg::PH_DCR;
          end else j.kind = trn_pkg::MSG_DATA2;
        end
        trn_pkg::PH_CMD: begin
          phase_d = trn_pkg::PH_DATA;
          if (b == trn_pkg::B_IAC) begin
            j.kind = trn_pkg::MSG_DATA1; j.b0 = b;
          end else if (b >= trn_pkg::B_WILL && b <= trn_pkg::B_DONT) begin
            verb_d = 2'(b - trn_pkg::B_WILL); phase_d = trn_pkg::PH_NEG;
          end else if (b == trn_pkg::B_SB) begin
            cnt_d = 2'd0; phase_d = trn_pkg::PH_SUB;
          end
        end
        trn_pkg::PH_NEG: begin
          phase_d = trn_pkg::PH_DATA;
          j.o0 = b;
          unique case (verb_q)
            2'd2: begin // DO
              j.v0 = trn_pkg::B_WILL;
              if (b == trn_pkg::OPT_BIN) begin
                if (!lbon_q && !lbask_q) j.kind = trn_pkg::MSG_R3;
                lbon_d = 1'b1; lbask_d = 1'b0;
              end else if (b == trn_pkg::OPT_TTYPE) begin
                if (!tt_q) j.kind = trn_pkg::MSG_R3;
                tt_d = 1'b1;
              end else if (b == trn_pkg::OPT_NAWS) begin
                j.kind = ws_q ? trn_pkg::MSG_NAWS : trn_pkg::MSG_R3NAWS;
                ws_d = 1'b1;
              end else begin
                j.kind = trn_pkg::MSG_R3; j.v0 = trn_pkg::B_WONT;
              end
            end
            2'd3: begin // DONT
              if (b == trn_pkg::OPT_BIN) begin
                lbon_d = 1'b0; lbask_d = 1'b0;
                if (lbask_q) ref_d = 1'b1;
              end
              if (b == trn_pkg::OPT_NAWS) ws_d = 1'b0;
              if (b == trn_pkg::OPT_TTYPE) tt_d = 1'b0;
              j.kind = trn_pkg::MSG_R3; j.v0 = trn_pkg::B_WONT;
            end
            2'd0: begin // WILL
              j.v0 = trn_pkg::B_DO;
              if (b == trn_pkg::OPT_BIN) begin
                if (!rbon_q && !rbask_q) j.kind = trn_pkg::MSG_R3;
                rbon_d = 1'b1; rbask_d = 1'b0;
              end else if (b == trn_pkg::OPT_ECHO || b == trn_pkg::OPT_SGA) begin
                j.kind = trn_pkg::MSG_R3;
              end else begin
                j.kind = trn_pkg::MSG_R3; j.v0 = trn_pkg::B_DONT;
              end
            end
            default: begin // WONT
              if (b == trn_pkg::OPT_BIN) begin
                rbon_d = 1'b0; rbask_d = 1'b0;
                if (rbask_q) ref_d = 1'b1;
              end
              j.kind = trn_pkg::MSG_R3; j.v0 = trn_pkg::B_DONT;
            end
          endcase
        end
        trn_pkg::PH_SUB, trn_pkg::PH_SUBCMD: begin
          if (phase_q == trn_pkg::PH_SUB && b == trn_pkg::B_IAC) begin
            phase_d = trn_pkg::PH_SUBCMD;
          end else if (phase_q == trn_pkg::PH_SUB || b == trn_pkg::B_IAC) begin
            phase_d = trn_pkg::PH_SUB;
            if (cnt_q == 2'd0) begin h0_d = b; cnt_d = 2'd1; end
            else if (cnt_q == 2'd1) begin h1_d = b; cnt_d = 2'd2; end
          end else begin
            phase_d = trn_pkg::PH_DATA;
            if (b == trn_pkg::B_SE) begin
              cnt_d = 2'd0;
              if (tt_q && cnt_q == 2'd2 && h0_q == trn_pkg::OPT_TTYPE && h1_q == 8'd1)
                j.kind = trn_pkg::MSG_TTYPE;
            end
          end
        end
        default: begin
          phase_d = trn_pkg::PH_DATA;
          j.b0 = b;
          if (b == trn_pkg::B_IAC) phase_d = trn_pkg::PH_CMD;
          else if (rbon_q) j.kind = trn_pkg::MSG_DATA1;
          else if (b == trn_pkg::B_CR) phase_d = trn_pkg::PH_DCR;
          else if (b != 8'd0) j.kind = trn_pkg::MSG_DATA1;
        end
      endcase
    end
    j.naws_on = ws_d;
    j.binary_on = lbon_d & rbon_d;
    j.binary_refused = ref_d;
  end

  assign job_o = j;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= trn_pkg::PH_DATA; verb_q <= '0;
      lbon_q <= 1'b0; lbask_q <= 1'b0; rbon_q <= 1'b0; rbask_q <= 1'b0;
      tt_q <= 1'b0; ws_q <= 1'b0; ref_q <= 1'b0; cnt_q <= '0;
      h0_q <= '0; h1_q <= '0;
    end else if (take_i) begin
      phase_q <= phase_d; verb_q <= verb_d;
      lbon_q <= lbon_d; lbask_q <= lbask_d; rbon_q <= rbon_d; rbask_q <= rbask_d;
      tt_q <= tt_d; ws_q <= ws_d; ref_q <= ref_d; cnt_q <= cnt_d;
      h0_q <= h0_d; h1_q <= h1_d;
    end
  end

  // accepted asks flags are cleared whenever the direction turns on
  assert property (@(posedge clk_i) disable iff (!rst_ni) lbon_q |-> !lbask_q)
    else $error("local binary on and asked");
  assert property (@(posedge clk_i) disable iff (!rst_ni) rbon_q |-> !rbask_q)
    else $error("remote binary on and asked");
  assert property (@(posedge clk_i) disable iff (!rst_ni) $onehot(phase_q))
    else $error("phase not one-hot");

endmodule

/* sim/trn_checker.sv */
// Watches both channels, predicts the result words of each accepted input
// word and compares them in order with what the block emits.
module trn_checker #(
  parameter int unsigned TERM_TYPE_MAX = 8
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      cfg_we_i,
  input  logic [1:0] cfg_index_i,
  input  logic [63:0] cfg_data_i,
  input  logic      in_valid_i,
  input  logic      in_stall_i,
  input  trn_pkg::in_word_t  in_data_i,
  input  logic      out_valid_i,
  input  logic      out_stall_i,
  input  trn_pkg::out_word_t out_data_i,
  output int        fail_count_o,
  output int        pending_o,
  output int        seen_o
);

  // parser phase codes of the predictor
  typedef enum int {
    P_DATA, P_DCR, P_CMD, P_NEG, P_SUB, P_SUBCMD
  } pphase_e;

  trn_pkg::out_word_t expected_q[$];

  logic [15:0] cols, rows;
  logic [63:0] ttext;
  logic [3:0]  tlen;
  pphase_e     phase;
  logic [1:0]  verb_sel;
  logic        lb_on, lb_ask, rb_on, rb_ask, tt_on, ws_on, refused;
  int          sub_cnt;
  logic [7:0]  sub_h0, sub_h1;

  // burst being built for the current word
  logic [7:0] bb[$];
  logic       bc[$];
  logic       be[$];

  function automatic void put(logic ch, logic [7:0] b);
    if (bb.size() < trn_pkg::MAX_RES) begin
      bc.insert(bc.size(), ch); bb.insert(bb.size(), b); be.insert(be.size(), 1'b0);
    end
  endfunction

  function automatic void put_esc(logic [7:0] b);
    put(1'b1, b);
    if (b == trn_pkg::B_IAC) put(1'b1, trn_pkg::B_IAC);
  endfunction

  function automatic void end_msg();
    if (be.size() > 0) be[be.size()-1] = 1'b1;
  endfunction

  function automatic void reply3(logic [7:0] v, logic [7:0] o);
    put(1'b1, trn_pkg::B_IAC); put(1'b1, v); put(1'b1, o); end_msg();
  endfunction

  function automatic void send_winsize();
    put(1'b1, trn_pkg::B_IAC); put(1'b1, trn_pkg::B_SB); put(1'b1, trn_pkg::OPT_NAWS);
    put_esc(cols[15:8]); put_esc(cols[7:0]);
    put_esc(rows[15:8]); put_esc(rows[7:0]);
    put(1'b1, trn_pkg::B_IAC); put(1'b1, trn_pkg::B_SE); end_msg();
  endfunction

  function automatic void data_byte(logic [7:0] b);
    if (b == trn_pkg::B_IAC) phase = P_CMD;
    else if (rb_on) put(1'b0, b);
    else if (b == trn_pkg::B_CR) phase = P_DCR;
    else if (b != 8'd0) put(1'b0, b);
  endfunction

  function automatic void negotiate(logic [7:0] opt);
    case (verb_sel)
      2'd2: begin // DO
        if (opt == trn_pkg::OPT_BIN) begin
          if (!lb_on && !lb_ask) reply3(trn_pkg::B_WILL, trn_pkg::OPT_BIN);
          lb_on = 1'b1; lb_ask = 1'b0;
        end else if (opt == trn_pkg::OPT_TTYPE) begin
          if (!tt_on) reply3(trn_pkg::B_WILL, trn_pkg::OPT_TTYPE);
          tt_on = 1'b1;
        end else if (opt == trn_pkg::OPT_NAWS) begin
          if (!ws_on) reply3(trn_pkg::B_WILL, trn_pkg::OPT_NAWS);
          ws_on = 1'b1;
          send_winsize();
        end else reply3(trn_pkg::B_WONT, opt);
      end
      2'd3: begin // DONT
        if (opt == trn_pkg::OPT_BIN) begin
          lb_on = 1'b0;
          if (lb_ask) refused = 1'b1;
          lb_ask = 1'b0;
        end
        if (opt == trn_pkg::OPT_NAWS) ws_on = 1'b0;
        if (opt == trn_pkg::OPT_TTYPE) tt_on = 1'b0;
        reply3(trn_pkg::B_WONT, opt);
      end
      2'd0: begin // WILL
        if (opt == trn_pkg::OPT_BIN) begin
          if (!rb_on && !rb_ask) reply3(trn_pkg::B_DO, trn_pkg::OPT_BIN);
          rb_on = 1'b1; rb_ask = 1'b0;
        end else if (opt == trn_pkg::OPT_ECHO || opt == trn_pkg::OPT_SGA)
          reply3(trn_pkg::B_DO, opt);
        else reply3(trn_pkg::B_DONT, opt);
      end
      default: begin // WONT
        if (opt == trn_pkg::OPT_BIN) begin
          rb_on = 1'b0;
          if (rb_ask) refused = 1'b1;
          rb_ask = 1'b0;
        end
        reply3(trn_pkg::B_DONT, opt);
      end
    endcase
  endfunction

  function automatic void sub_push(logic [7:0] b);
    if (sub_cnt == 0) begin sub_h0 = b; sub_cnt = 1; end
    else if (sub_cnt == 1) begin sub_h1 = b; sub_cnt = 2; end
  endfunction

  function automatic void sub_finish();
    int n;
    if (tt_on && sub_cnt >= 2 && sub_h0 == trn_pkg::OPT_TTYPE && sub_h1 == 8'd1) begin
      n = (tlen > TERM_TYPE_MAX) ? TERM_TYPE_MAX : int'(tlen);
      put(1'b1, trn_pkg::B_IAC); put(1'b1, trn_pkg::B_SB);
      put(1'b1, trn_pkg::OPT_TTYPE); put(1'b1, 8'd0);
      for (int i = 0; i < n; i++) put_esc(ttext[8*i +: 8]);
      put(1'b1, trn_pkg::B_IAC); put(1'b1, trn_pkg::B_SE); end_msg();
    end
    sub_cnt = 0;
  endfunction

  function automatic void parse_byte(logic [7:0] b);
    case (phase)
      P_DCR: begin
        put(1'b0, trn_pkg::B_CR);
        phase = P_DATA;
        if (b == trn_pkg::B_LF) put(1'b0, trn_pkg::B_LF);
        else if (b != 8'd0) data_byte(b);
      end
      P_CMD: begin
        if (b == trn_pkg::B_IAC) begin put(1'b0, trn_pkg::B_IAC); phase = P_DATA; end
        else if (b >= trn_pkg::B_WILL && b <= trn_pkg::B_DONT) begin
          verb_sel = 2'(b - trn_pkg::B_WILL); phase = P_NEG;
        end else if (b == trn_pkg::B_SB) begin sub_cnt = 0; phase = P_SUB; end
        else phase = P_DATA;
      end
      P_NEG: begin negotiate(b); phase = P_DATA; end
      P_SUB: begin
        if (b == trn_pkg::B_IAC) phase = P_SUBCMD;
        else sub_push(b);
      end
      P_SUBCMD: begin
        if (b == trn_pkg::B_IAC) begin sub_push(trn_pkg::B_IAC); phase = P_SUB; end
        else begin
          if (b == trn_pkg::B_SE) sub_finish();
          phase = P_DATA;
        end
      end
      default: begin phase = P_DATA; data_byte(b); end
    endcase
  endfunction

  // predict one accepted input word and queue its result words
  function automatic void predict_word(trn_pkg::in_word_t w);
    trn_pkg::out_word_t r;
    bb.delete(); bc.delete(); be.delete();
    if (w.mode) begin
      refused = 1'b0;
      if (!lb_on) lb_ask = 1'b1;
      if (!rb_on) rb_ask = 1'b1;
      if (!lb_on) reply3(trn_pkg::B_WILL, trn_pkg::OPT_BIN);
      if (!rb_on) reply3(trn_pkg::B_DO, trn_pkg::OPT_BIN);
    end else parse_byte(w.rx_byte);
    foreach (bb[k]) begin
      r.channel = bc[k];
      r.out_byte = bb[k];
      r.message_end = be[k];
      r.run_last = (k == bb.size() - 1);
      r.naws_on = ws_on;
      r.binary_on = lb_on && rb_on;
      r.binary_refused = refused;
      expected_q.insert(expected_q.size(), r);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    trn_pkg::out_word_t e;
    if (!rst_ni) begin
      cols = '0; rows = '0; ttext = '0; tlen = '0;
      phase = P_DATA; verb_sel = '0;
      lb_on = 0; lb_ask = 0; rb_on = 0; rb_ask = 0;
      tt_on = 0; ws_on = 0; refused = 0;
      sub_cnt = 0; sub_h0 = '0; sub_h1 = '0;
      fail_count_o = 0; seen_o = 0;
      expected_q.delete();
    end else begin
      // register writes
      if (cfg_we_i) begin
        case (cfg_index_i)
          trn_pkg::REG_COLS:  cols = cfg_data_i[15:0];
          trn_pkg::REG_ROWS:  rows = cfg_data_i[15:0];
          trn_pkg::REG_TTEXT: ttext = cfg_data_i;
          default:            tlen = cfg_data_i[3:0];
        endcase
      end
      // result side
      if (out_valid_i && !out_stall_i) begin
        seen_o++;
        if (expected_q.size() == 0) begin
          $error("unexpected result word %h", out_data_i);
          fail_count_o++;
        end else begin
          e = expected_q.pop_front();
          if (e.channel != out_data_i.channel) begin
            $error("channel exp %0d got %0d", e.channel, out_data_i.channel);
            fail_count_o++;
          end
          if (e.out_byte != out_data_i.out_byte) begin
            $error("out_byte exp %0d got %0d", e.out_byte, out_data_i.out_byte);
            fail_count_o++;
          end
          if (e.message_end != out_data_i.message_end) begin
            $error("message_end exp %0d got %0d", e.message_end,
                   out_data_i.message_end);
            fail_count_o++;
          end
          if (e.run_last != out_data_i.run_last) begin
            $error("run_last exp %0d got %0d", e.run_last, out_data_i.run_last);
            fail_count_o++;
          end
          if (e.naws_on != out_data_i.naws_on) begin
            $error("naws_on exp %0d got %0d", e.naws_on, out_data_i.naws_on);
            fail_count_o++;
          end
          if (e.binary_on != out_data_i.binary_on) begin
            $error("binary_on exp %0d got %0d", e.binary_on, out_data_i.binary_on);
            fail_count_o++;
          end
          if (e.binary_refused != out_data_i.binary_refused) begin
            $error("binary_refused exp %0d got %0d", e.binary_refused,
                   out_data_i.binary_refused);
            fail_count_o++;
          end
        end
      end
      // input side
      if (in_valid_i && !in_stall_i) predict_word(in_data_i);
    end
  end

  assign pending_o = expected_q.size();

endmodule

/* sim/tb_top.sv */
// Drives words and register writes into the negotiator and gives the verdict.
module tb_top;

  localparam int LIMIT = 400000;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      cfg_we_i = 1'b0;
  logic [1:0] cfg_index_i = '0;
  logic [63:0] cfg_data_i = '0;
  logic      in_valid_i = 1'b0;
  logic      in_stall_o;
  trn_pkg::in_word_t  in_data_i = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  trn_pkg::out_word_t out_data_o;
  int        fail_count, pending, seen;
  int        cycles = 0;
  int        sent = 0;
  int        gap_left = 0;
  int        burst_left = 0;
  bit        no_idle = 1'b0;

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  telnet_receive_negotiator uut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_stall_o, .in_data_i,
    .out_valid_o, .out_stall_i, .out_data_o
  );

  trn_checker chk (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_stall_i(in_stall_o), .in_data_i,
    .out_valid_i(out_valid_o), .out_stall_i, .out_data_i(out_data_o),
    .fail_count_o(fail_count), .pending_o(pending), .seen_o(seen)
  );

  // run limit
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // receiver stall pattern: rotating mask plus random extra stalls
  always @(posedge clk_i) begin
    if (no_idle) out_stall_i <= 1'b0;
    else out_stall_i <= ((cycles % 7) < 2) || ($urandom_range(0, 5) == 0);
  end

  task automatic cfg_write(logic [1:0] idx, logic [63:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1; cfg_index_i <= idx; cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic drain();
    while (pending != 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
  endtask

  // send one word with burst/gap idling in front of it
  task automatic send_word(logic m, logic [7:0] b);
    if (!no_idle) begin
      if (burst_left == 0) begin
        gap_left = $urandom_range(0, 4);
        burst_left = $urandom_range(1, 12);
      end
      if (gap_left > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap_left) @(posedge clk_i);
        gap_left = 0;
      end
      burst_left--;
    end
    in_valid_i <= 1'b1;
    in_data_i <= '{mode: m, rx_byte: b};
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sent++;
  endtask

  task automatic stop_words();
    in_valid_i <= 1'b0;
  endtask

  task automatic send_neg(logic [7:0] verb, logic [7:0] opt);
    send_word(1'b0, trn_pkg::B_IAC); send_word(1'b0, verb); send_word(1'b0, opt);
  endtask

  // random well-formed sequences plus noise
  task automatic random_phase(int n);
    int k;
    logic [7:0] opts[5];
    opts = '{trn_pkg::OPT_BIN, trn_pkg::OPT_ECHO, trn_pkg::OPT_SGA,
             trn_pkg::OPT_TTYPE, trn_pkg::OPT_NAWS};
    while (n > 0) begin
      k = $urandom_range(0, 9);
      case (k)
        0, 1: begin send_word(1'b0, 8'($urandom)); n--; end
        2: begin
          send_neg(8'($urandom_range(251, 254)),
                   ($urandom_range(0, 4) == 0) ? 8'($urandom) : opts[$urandom_range(0, 4)]);
          n -= 3;
        end
        3: begin
          send_word(1'b0, trn_pkg::B_IAC); send_word(1'b0, trn_pkg::B_SB);
          send_word(1'b0, ($urandom_range(0, 3) == 0) ? 8'($urandom) : trn_pkg::OPT_TTYPE);
          send_word(1'b0, ($urandom_range(0, 3) == 0) ? trn_pkg::B_IAC : 8'd1);
          if ($urandom_range(0, 2) == 0) send_word(1'b0, 8'($urandom));
          send_word(1'b0, trn_pkg::B_IAC);
          send_word(1'b0, ($urandom_range(0, 4) == 0) ? 8'($urandom) : trn_pkg::B_SE);
          n -= 6;
        end
        4: begin send_word(1'b0, trn_pkg::B_CR);
          send_word(1'b0, ($urandom_range(0, 1)) ? trn_pkg::B_LF
                                                 : 8'($urandom_range(0, 2) * 13));
          n -= 2;
        end
        5: begin send_word(1'b1, 8'($urandom)); n--; end
        6: begin send_word(1'b0, trn_pkg::B_IAC); send_word(1'b0, 8'($urandom)); n -= 2; end
        default: begin send_word(1'b0, 8'($urandom_range(32, 126))); n--; end
      endcase
    end
    stop_words();
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);
    cfg_write(trn_pkg::REG_COLS, 64'hFFFF);
    cfg_write(trn_pkg::REG_ROWS, 64'h00FF);
    cfg_write(trn_pkg::REG_TTEXT, 64'hFF41_5458_5054_56FF);
    cfg_write(trn_pkg::REG_TLEN, 64'd15);

    // directed: no idling, long escaped bursts and special cases
    no_idle = 1'b1;
    send_word(1'b0, 8'h00); send_word(1'b0, 8'h7F);
    send_word(1'b0, trn_pkg::B_CR); send_word(1'b0, trn_pkg::B_LF);
    send_word(1'b0, trn_pkg::B_CR); send_word(1'b0, 8'h00);
    send_word(1'b0, trn_pkg::B_CR); send_word(1'b0, 8'h41);
    send_word(1'b0, trn_pkg::B_IAC); send_word(1'b0, trn_pkg::B_IAC);
    send_word(1'b0, trn_pkg::B_IAC); send_word(1'b0, 8'd241);
    send_neg(trn_pkg::B_DO, trn_pkg::OPT_TTYPE);
    send_neg(trn_pkg::B_DO, trn_pkg::OPT_NAWS);
    send_word(1'b0, trn_pkg::B_IAC); send_word(1'b0, trn_pkg::B_SB);
    send_word(1'b0, trn_pkg::OPT_TTYPE); send_word(1'b0, 8'd1);
    send_word(1'b0, 8'd9); send_word(1'b0, trn_pkg::B_IAC);
    send_word(1'b0, trn_pkg::B_SE);
    send_word(1'b1, 8'hFF);
    send_neg(trn_pkg::B_DONT, trn_pkg::OPT_BIN);
    send_neg(trn_pkg::B_WONT, trn_pkg::OPT_BIN);
    send_neg(trn_pkg::B_WILL, trn_pkg::OPT_BIN); send_neg(trn_pkg::B_DO, trn_pkg::OPT_BIN);
    send_word(1'b0, trn_pkg::B_CR); send_word(1'b0, 8'h00);
    send_word(1'b0, trn_pkg::B_IAC); send_word(1'b0, trn_pkg::B_SB); send_word(1'b0, 8'd5);
    send_word(1'b0, trn_pkg::B_IAC); send_word(1'b0, 8'h20);
    stop_words();
    no_idle = 1'b0;
    drain();

    random_phase(140);
    drain();
    cfg_write(trn_pkg::REG_COLS, 64'd0);
    cfg_write(trn_pkg::REG_ROWS, 64'd0);
    cfg_write(trn_pkg::REG_TTEXT, 64'd0);
    cfg_write(trn_pkg::REG_TLEN, 64'd0);
    random_phase(120);
    drain();
    cfg_write(trn_pkg::REG_COLS, {48'd0, 16'($urandom)});
    cfg_write(trn_pkg::REG_ROWS, {48'd0, 16'($urandom)});
    cfg_write(trn_pkg::REG_TTEXT, {$urandom, $urandom});
    cfg_write(trn_pkg::REG_TLEN, 64'($urandom_range(0, 8)));
    random_phase(120);
    drain();

    $display("Sent %0d input words over three register settings; %0d result words checked.",
             sent, seen);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
